// File: rtl/core/ctbl_pkg.sv
// ----------------------------------------------------------------------------
// ctbl_pkg
// Shared types and constants for the cursor text buffer core.
// ----------------------------------------------------------------------------
`default_nettype none

package ctbl_pkg;

    localparam int POOL_NODES_DEF = 1024;

    typedef enum logic [2:0] {
        F_LEFT     = 3'd0,
        F_RIGHT    = 3'd1,
        F_INSERT   = 3'd2,
        F_BACK     = 3'd3,
        F_RD_START = 3'd4,
        F_RD_NEXT  = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2,
        ST_END     = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] char_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] char_out;
    } t_out_item;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_FIN  = 1'b1
    } t_state;

    typedef struct packed {
        logic issue;
        logic finish;
    } t_dp_cmd;

endpackage

`default_nettype wire

// File: rtl/core/ctbl_ctrl.sv
// ----------------------------------------------------------------------------
// ctbl_ctrl
// Command sequencer: accepts an item and steps the datapath through the
// issue and finish phases.
// ----------------------------------------------------------------------------
`default_nettype none

module ctbl_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    output logic                  o_busy,
    output ctbl_pkg::t_dp_cmd     o_cmd
);

    ctbl_pkg::t_state r_state;
    ctbl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ctbl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_busy       = 1'b0;
        o_cmd.issue  = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            ctbl_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.issue = 1'b1;
                    n_state     = ctbl_pkg::S_FIN;
                end
            end
            ctbl_pkg::S_FIN: begin
                o_busy       = 1'b1;
                o_cmd.finish = 1'b1;
                n_state      = ctbl_pkg::S_IDLE;
            end
            default: begin
                n_state = ctbl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/ctbl_dp.sv
// ----------------------------------------------------------------------------
// ctbl_dp
// Link and character memories, sentinel links, cursor, pool and readout
// pointers, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctbl_dp #(
    parameter int POOL_NODES = ctbl_pkg::POOL_NODES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ctbl_pkg::t_dp_cmd    i_cmd,
    input  wire ctbl_pkg::t_in_item   i_item,
    output logic                      o_valid,
    output ctbl_pkg::t_out_item       o_item
);

    localparam int AW = $clog2(POOL_NODES);
    localparam int LW = $clog2(POOL_NODES + 1);
    localparam logic [LW-1:0] NIL = LW'(POOL_NODES);

    logic [LW-1:0] r_prev_mem [POOL_NODES];
    logic [LW-1:0] r_next_mem [POOL_NODES];
    logic [7:0]    r_char_mem [POOL_NODES];

    logic [LW-1:0] r_rd_prev;
    logic [LW-1:0] r_rd_next;
    logic [7:0]    r_rd_char;

    logic [AW-1:0] r_cursor, n_cursor;
    logic [LW-1:0] r_free,   n_free;
    logic [LW-1:0] r_read,   n_read;
    logic [LW-1:0] r_head,   n_head;
    logic [LW-1:0] r_tail,   n_tail;
    logic [2:0]    r_func;
    logic          r_valid;
    ctbl_pkg::t_out_item r_out, n_out;

    logic          pool_full;
    logic          at_sentinel;
    logic [LW-1:0] cur_next;
    logic [LW-1:0] tail_node;
    logic [LW-1:0] prv_node;

    logic          nx_we, pv_we, ch_we;
    logic [AW-1:0] nx_wa, pv_wa, nx_ra;
    logic [LW-1:0] nx_wd, pv_wd;

    assign pool_full   = (r_free == NIL);
    assign at_sentinel = (r_cursor == '0);
    assign cur_next    = at_sentinel ? r_head : r_rd_next;
    assign tail_node   = (r_tail < NIL) ? r_tail : '0;
    assign prv_node    = (r_rd_prev < NIL) ? r_rd_prev : '0;
    assign nx_ra       = (ctbl_pkg::t_func'(i_item.func) == ctbl_pkg::F_RD_NEXT)
                         ? r_read[AW-1:0] : r_cursor;

    always_comb begin
        n_cursor       = r_cursor;
        n_free         = r_free;
        n_read         = r_read;
        n_head         = r_head;
        n_tail         = r_tail;
        n_out.status   = ctbl_pkg::ST_DONE;
        n_out.char_out = '0;
        nx_we          = 1'b0;
        nx_wa          = r_cursor;
        nx_wd          = r_free;
        pv_we          = 1'b0;
        pv_wa          = r_free[AW-1:0];
        pv_wd          = LW'(r_cursor);
        ch_we          = 1'b0;
        if (i_cmd.issue) begin
            // insert: new node gets its back link and byte, cursor node points at it
            if (ctbl_pkg::t_func'(i_item.func) == ctbl_pkg::F_INSERT && !pool_full) begin
                pv_we = 1'b1;
                ch_we = 1'b1;
                nx_we = !at_sentinel;
            end
        end else if (i_cmd.finish) begin
            case (ctbl_pkg::t_func'(r_func))
                ctbl_pkg::F_LEFT: begin
                    if (!at_sentinel) begin
                        n_cursor = (r_rd_prev < NIL) ? r_rd_prev[AW-1:0] : '0;
                    end else begin
                        n_out.status = ctbl_pkg::ST_IGNORED;
                    end
                end
                ctbl_pkg::F_RIGHT: begin
                    if (LW'(r_cursor) != tail_node && cur_next < NIL) begin
                        n_cursor = cur_next[AW-1:0];
                    end else begin
                        n_out.status = ctbl_pkg::ST_IGNORED;
                    end
                end
                ctbl_pkg::F_INSERT: begin
                    if (!pool_full) begin
                        nx_we = 1'b1;
                        nx_wa = r_free[AW-1:0];
                        nx_wd = cur_next;
                        if (cur_next != NIL) begin
                            pv_we = 1'b1;
                            pv_wa = cur_next[AW-1:0];
                            pv_wd = r_free;
                        end else begin
                            n_tail = r_free;
                        end
                        if (at_sentinel) begin
                            n_head = r_free;
                        end
                        n_cursor = r_free[AW-1:0];
                        n_free   = r_free + LW'(1);
                    end else begin
                        n_out.status = ctbl_pkg::ST_FULL;
                    end
                end
                ctbl_pkg::F_BACK: begin
                    if (!at_sentinel) begin
                        if (prv_node == '0) begin
                            n_head = r_rd_next;
                        end else begin
                            nx_we = 1'b1;
                            nx_wa = prv_node[AW-1:0];
                            nx_wd = r_rd_next;
                        end
                        if (r_rd_next != NIL) begin
                            pv_we = 1'b1;
                            pv_wa = r_rd_next[AW-1:0];
                            pv_wd = prv_node;
                        end else begin
                            n_tail = prv_node;
                        end
                        n_cursor = prv_node[AW-1:0];
                    end else begin
                        n_out.status = ctbl_pkg::ST_IGNORED;
                    end
                end
                ctbl_pkg::F_RD_START: begin
                    n_read = r_head;
                end
                ctbl_pkg::F_RD_NEXT: begin
                    if (r_read < NIL) begin
                        n_out.char_out = r_rd_char;
                        n_read         = r_rd_next;
                    end else begin
                        n_out.status = ctbl_pkg::ST_END;
                    end
                end
                default: begin
                    n_out.status = ctbl_pkg::ST_IGNORED;
                end
            endcase
        end
    end

    // read-first memories
    always_ff @(posedge i_clk) begin
        if (nx_we) begin
            r_next_mem[nx_wa] <= nx_wd;
        end
        r_rd_next <= r_next_mem[nx_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pv_we) begin
            r_prev_mem[pv_wa] <= pv_wd;
        end
        r_rd_prev <= r_prev_mem[r_cursor];
    end

    always_ff @(posedge i_clk) begin
        if (ch_we) begin
            r_char_mem[r_free[AW-1:0]] <= i_item.char_in;
        end
        r_rd_char <= r_char_mem[r_read[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_free   <= LW'(1);
            r_read   <= NIL;
            r_head   <= NIL;
            r_tail   <= NIL;
            r_valid  <= 1'b0;
        end else begin
            r_cursor <= n_cursor;
            r_free   <= n_free;
            r_read   <= n_read;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_valid  <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_func <= i_item.func;
        end
        r_out <= n_out;
    end

    assign o_valid = r_valid;
    assign o_item  = r_out;

endmodule

`default_nettype wire

// File: rtl/core/cursor_text_buffer_linked_core.sv
// ----------------------------------------------------------------------------
// cursor_text_buffer_linked_core
// Text buffer kept as a doubly linked list with a cursor, driven by
// single-byte edit and readout commands.
// ----------------------------------------------------------------------------
// Busy is high for the cycle after start is taken, and the result shows on
// o_item with o_valid for the cycle after that, in which a new command may
// already be started; start is ignored while busy is high. The issue and
// finish phases come from the link memories: the issue phase reads the old
// links while the new node is written, the finish phase patches the
// neighbors. The result is shown for one cycle only and must be captured on
// o_valid. The sentinel links sit in flip-flops, so no clearing pass follows
// reset.
`default_nettype none

module cursor_text_buffer_linked_core #(
    parameter int POOL_NODES = ctbl_pkg::POOL_NODES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire ctbl_pkg::t_in_item   i_item,
    output logic                      o_valid,
    output ctbl_pkg::t_out_item       o_item
);

    ctbl_pkg::t_dp_cmd cmd;

    ctbl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    ctbl_dp #(
        .POOL_NODES (POOL_NODES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

endmodule

`default_nettype wire

// File: rtl/core/ctbl_chk.sv
// ----------------------------------------------------------------------------
// ctbl_chk
// Port-level timing checks for the cursor text buffer core.
// ----------------------------------------------------------------------------
`default_nettype none

module ctbl_chk (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic                 o_valid,
    input wire ctbl_pkg::t_out_item  o_item
);

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after start");

    a_result_two_later: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##2 o_valid)
        else $error("result missing two cycles after start");

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    a_char_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.char_out != 8'd0 |-> o_item.status == ctbl_pkg::ST_DONE)
        else $error("character returned with non-done status");

endmodule

bind cursor_text_buffer_linked_core ctbl_chk u_chk (.*);

`default_nettype wire
